// ----- rtl/bis_pkg.sv -----
// Shared types and codes for the bounded integer stack.
`timescale 1ns / 1ps

package bis_pkg;

  localparam int KIND_W   = 3;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 8;
  localparam int SIZE_W   = 9;
  localparam int CAP_W    = 9;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [SIZE_W-1:0]   size_t;
  typedef logic [CAP_W-1:0]    cap_t;

  localparam kind_t KIND_PUSH   = 3'd0;
  localparam kind_t KIND_POP    = 3'd1;
  localparam kind_t KIND_PEEK   = 3'd2;
  localparam kind_t KIND_CLEAR  = 3'd3;
  localparam kind_t KIND_SEARCH = 3'd4;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_REFUSED   = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;

  localparam cap_t CAP_RESET = 9'd256;

endpackage

// ----- rtl/bis_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/bounded_integer_stack.sv -----
// Bounded LIFO stack of signed words with top-down search.
//
// Requests enter on the in channel (kind, value) and each gives one result on
// the out channel (status, data, position, size, empty_res, full_res). Both
// channels move an item when valid is high and stall is low. The capacity
// register is written over the cfg channel (cfg_valid, cfg_ready, cfg_data);
// cfg_ready is always high. Capacity is clipped to DEPTH.
// One request is in flight at a time; in_stall is high while it is worked.
// Steps from acceptance to out_valid: push, clear, unused kinds, any refused
// request and a search of an empty stack go straight to S_DONE; pop and peek
// pass S_READ (one RAM read); search passes S_SCAN, where one comparator walks
// the RAM from the top one entry per cycle until a match or the bottom. A new
// request is taken only once the previous result is loaded into the output
// register and the sequencer is back in S_IDLE, so requests never overlap.
// A stalled receiver holds the output register; a finished result then waits
// in the sequencer and the input stays stalled.
// Synchronous reset empties the stack, sets capacity to 256 and drops any
// pending result. Stored words are not cleared.
`timescale 1ns / 1ps

module bounded_integer_stack #(
  parameter int DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  bis_pkg::cap_t         cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bis_pkg::kind_t        kind,
  input  logic signed [31:0]    value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bis_pkg::status_t      status,
  output logic signed [31:0]    data,
  output bis_pkg::pos_t         position,
  output bis_pkg::size_t        size,
  output logic                  empty_res,
  output logic                  full_res
);

  import bis_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] count;
  cap_t          capacity;
  logic [AW-1:0] idx;
  word_t         key;
  status_t       res_status;
  word_t         res_data;
  pos_t          res_pos;

  logic          in_fire;
  logic          load_out;
  logic          full_now;
  logic          empty_now;
  logic [AW-1:0] top_addr;
  logic [AW-1:0] rd_addr;
  word_t         rd_data;
  logic          wr_en;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign load_out  = (state == S_DONE) && (!out_valid || !out_stall);

  assign empty_now = (count == '0);
  assign full_now  = (CMPW'(count) >= CMPW'(capacity)) || (CMPW'(count) >= CMPW'(DEPTH));
  assign top_addr  = AW'(count - CW'(1));
  assign rd_addr   = (state == S_SCAN) ? (idx - AW'(1)) : top_addr;
  assign wr_en     = in_fire && (kind == KIND_PUSH) && !full_now;

  bis_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(count)),
    .wr_data (word_t'(value)),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      capacity  <= CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        capacity <= cfg_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            res_data <= '0;
            res_pos  <= '0;
            case (kind)
              KIND_PUSH: begin
                state <= S_DONE;
                if (full_now) begin
                  res_status <= ST_REFUSED;
                end else begin
                  res_status <= ST_OK;
                  count      <= count + CW'(1);
                end
              end
              KIND_POP: begin
                if (empty_now) begin
                  res_status <= ST_REFUSED;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  count      <= count - CW'(1);
                  state      <= S_READ;
                end
              end
              KIND_PEEK: begin
                if (empty_now) begin
                  res_status <= ST_REFUSED;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_READ;
                end
              end
              KIND_CLEAR: begin
                res_status <= ST_OK;
                count      <= '0;
                state      <= S_DONE;
              end
              KIND_SEARCH: begin
                if (empty_now) begin
                  res_status <= ST_NOT_FOUND;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  idx        <= top_addr;
                  key        <= word_t'(value);
                  state      <= S_SCAN;
                end
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end

        S_READ: begin
          res_data <= rd_data;
          state    <= S_DONE;
        end

        // rd_data holds the entry at idx; walk down one entry a cycle
        S_SCAN: begin
          if (rd_data == key) begin
            res_pos <= POS_W'(idx);
            state   <= S_DONE;
          end else if (idx == '0) begin
            res_status <= ST_NOT_FOUND;
            state      <= S_DONE;
          end else begin
            idx <= idx - AW'(1);
          end
        end

        S_DONE: begin
          // hold the result until the output register is free
          if (load_out) begin
            status    <= res_status;
            data      <= res_data;
            position  <= res_pos;
            size      <= SIZE_W'(count);
            empty_res <= empty_now;
            full_res  <= full_now;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- dv/tb_bounded_integer_stack.sv -----
// Testbench for the bounded integer stack: predicts every result and checks it field by field.
`timescale 1ns / 1ps

module tb_bounded_integer_stack;
  import bis_pkg::*;

  localparam int    STACK_DEPTH   = 256;
  localparam int    CYCLE_LIMIT   = 1000000;
  localparam int    MAX_WAIT      = 10;
  localparam kind_t KIND_SPARE_LO = KIND_SEARCH + 3'd1;
  localparam kind_t KIND_SPARE_HI = '1;
  localparam cap_t  CAP_MAX       = '1;

  typedef struct packed {
    status_t status;
    word_t   data;
    pos_t    position;
    size_t   size;
    logic    empty;
    logic    full;
  } stack_result_t;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  cap_t               cfg_data;
  logic               in_valid;
  logic               in_stall;
  kind_t              kind;
  logic signed [31:0] value;
  logic               out_valid;
  logic               out_stall;
  status_t            status;
  logic signed [31:0] data;
  pos_t               position;
  size_t              size;
  logic               empty_res;
  logic               full_res;

  // Own copy of the stack contents and capacity
  word_t         held_words [STACK_DEPTH];
  int unsigned   held_count;
  cap_t          capacity_reg;
  stack_result_t pending_results [$];

  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned rx_wait      = 0;
  int unsigned rx_long_hold = 0;
  bit          calm         = 1'b0;

  bounded_integer_stack #(.DEPTH(STACK_DEPTH)) DUT (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic stack_result_t stack_apply(kind_t k, word_t v);
    stack_result_t r;
    int unsigned   limit;
    int unsigned   i;
    r = '0;
    limit = (capacity_reg > STACK_DEPTH) ? STACK_DEPTH : capacity_reg;
    case (k)
      KIND_PUSH: begin
        if (held_count >= limit) begin
          r.status = ST_REFUSED;
        end else begin
          held_words[held_count] = v;
          held_count++;
        end
      end
      KIND_POP: begin
        if (held_count == 0) begin
          r.status = ST_REFUSED;
        end else begin
          held_count--;
          r.data = held_words[held_count];
        end
      end
      KIND_PEEK: begin
        if (held_count == 0) r.status = ST_REFUSED;
        else r.data = held_words[held_count - 1];
      end
      KIND_CLEAR: held_count = 0;
      KIND_SEARCH: begin
        // walk down from the top; the nearest match wins
        r.status = ST_NOT_FOUND;
        i = held_count;
        while (i > 0 && r.status == ST_NOT_FOUND) begin
          i--;
          if (held_words[i] == v) begin
            r.status = ST_OK;
            r.position = pos_t'(i);
          end
        end
      end
      default: ;
    endcase
    r.size  = size_t'(held_count);
    r.empty = (held_count == 0);
    r.full  = (held_count >= limit);
    return r;
  endfunction

  // Offer one item after a random gap; returns at the falling edge after acceptance
  task automatic send_request(kind_t k, word_t v);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(stack_apply(k, v));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(cap_t c);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    do @(posedge clk); while (!cfg_ready);
    capacity_reg = c;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic word_t held_or_random(int unsigned odds);
    if (held_count != 0 && $urandom_range(0, 3) < odds)
      return held_words[$urandom_range(0, held_count - 1)];
    return $urandom();
  endfunction

  // Receiver: per-item wait, plus a long hold when requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_long_hold != 0) begin
        out_stall <= 1'b1;
        rx_long_hold--;
      end else if (rx_wait != 0) begin
        out_stall <= 1'b1;
        rx_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    stack_result_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      rx_wait = calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (pending_results.size() == 0) begin
        $error("result item with no request outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          error_count++;
        end
        if (data !== want.data) begin
          $error("data: expected %0d, got %0d", $signed(want.data), data);
          error_count++;
        end
        if (position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, position);
          error_count++;
        end
        if (size !== want.size) begin
          $error("size: expected %0d, got %0d", want.size, size);
          error_count++;
        end
        if (empty_res !== want.empty) begin
          $error("empty_res: expected %0b, got %0b", want.empty, empty_res);
          error_count++;
        end
        if (full_res !== want.full) begin
          $error("full_res: expected %0b, got %0b", want.full, full_res);
          error_count++;
        end
      end
    end
  end

  task automatic test_empty_stack();
    int k;
    send_request(KIND_POP, '0);
    send_request(KIND_PEEK, '0);
    send_request(KIND_SEARCH, '0);
    send_request(KIND_CLEAR, '0);
    for (k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++) send_request(kind_t'(k), $urandom());
  endtask

  task automatic test_word_extremes();
    send_request(KIND_PUSH, 32'h8000_0000);
    send_request(KIND_PUSH, 32'h7FFF_FFFF);
    send_request(KIND_PUSH, '0);
    send_request(KIND_PUSH, '1);
    send_request(KIND_PUSH, 32'h7FFF_FFFF);
    send_request(KIND_PEEK, '0);
    // duplicate word: the one nearer the top must be reported
    send_request(KIND_SEARCH, 32'h7FFF_FFFF);
    send_request(KIND_SEARCH, 32'h8000_0000);
    send_request(KIND_SEARCH, 32'h1234_5678);
    send_request(KIND_POP, '0);
    send_request(KIND_POP, '0);
    send_request(KIND_SPARE_HI, '1);
    send_request(KIND_CLEAR, '0);
    send_request(KIND_POP, '0);
  endtask

  task automatic test_capacity_edges();
    write_capacity('0);
    send_request(KIND_PUSH, $urandom());
    send_request(KIND_PEEK, '0);
    write_capacity(9'd1);
    send_request(KIND_PUSH, $urandom());
    send_request(KIND_PUSH, $urandom());
    write_capacity(9'd3);
    send_request(KIND_PUSH, $urandom());
    send_request(KIND_PUSH, $urandom());
    // lower capacity below the held size; entries stay
    write_capacity(9'd1);
    send_request(KIND_PUSH, $urandom());
    send_request(KIND_POP, '0);
    send_request(KIND_PUSH, $urandom());
    send_request(KIND_POP, '0);
    send_request(KIND_POP, '0);
    send_request(KIND_PUSH, $urandom());
    write_capacity(CAP_MAX);
    send_request(KIND_PUSH, $urandom());
    send_request(KIND_CLEAR, '0);
  endtask

  task automatic test_fill_to_depth();
    int n;
    write_capacity(cap_t'(STACK_DEPTH + 1));
    for (n = 0; n < STACK_DEPTH; n++) begin
      calm = (n >= STACK_DEPTH / 2);
      send_request(KIND_PUSH, $urandom());
    end
    calm = 1'b0;
    send_request(KIND_PUSH, $urandom());
    // deepest walks: match at the bottom, then no match at all
    send_request(KIND_SEARCH, held_words[0]);
    send_request(KIND_SEARCH, $urandom());
    send_request(KIND_PEEK, '0);
    send_request(KIND_POP, '0);
    write_capacity(cap_t'(STACK_DEPTH - 1));
    send_request(KIND_PUSH, $urandom());
    send_request(KIND_CLEAR, '0);
  endtask

  task automatic test_output_backpressure();
    int n;
    wait_idle();
    calm = 1'b1;
    @(posedge clk);
    rx_long_hold = 300;
    @(negedge clk);
    // keep offering so the block fills and stalls its input
    for (n = 0; n < 12; n++) begin
      if (n % 4 == 3) send_request(KIND_SEARCH, held_or_random(3));
      else if (n % 4 == 2) send_request(KIND_POP, '0);
      else send_request(KIND_PUSH, $urandom());
    end
    wait_idle();
    calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    int          phase;
    int          n;
    int unsigned roll;
    cap_t        c;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: c = 9'd2;
        1: c = cap_t'($urandom_range(3, 20));
        2: c = '0;
        3: c = CAP_MAX;
        4: c = 9'd1;
        default: c = cap_t'($urandom_range(0, CAP_MAX));
      endcase
      write_capacity(c);
      calm = (phase == 3);
      for (n = 0; n < 55; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) send_request(KIND_PUSH, held_or_random(1));
        else if (roll < 65) send_request(KIND_POP, $urandom());
        else if (roll < 73) send_request(KIND_PEEK, $urandom());
        else if (roll < 91) send_request(KIND_SEARCH, held_or_random(3));
        else if (roll < 95) send_request(KIND_CLEAR, $urandom());
        else send_request(kind_t'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), $urandom());
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    kind         = KIND_PUSH;
    value        = '0;
    held_count   = 0;
    capacity_reg = CAP_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_stack();
    test_word_extremes();
    test_capacity_edges();
    test_fill_to_depth();
    test_output_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d result items never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
